### rtl/lma_pkg.sv
// ----------------------------------------------------------------------------
// lma_pkg
// Shared widths, register indexes and defaults for the layer morph attenuator.
// ----------------------------------------------------------------------------
`default_nettype none

package lma_pkg;

   // default array geometry
   localparam int LMA_NUM_LAYERS   = 8;
   localparam int LMA_NUM_CHANNELS = 16;

   // item field widths
   localparam int LMA_CH_W    = 4;
   localparam int LMA_LAYER_W = 3;
   localparam int LMA_LEVEL_W = 16;
   localparam int LMA_IN_W    = 56;
   localparam int LMA_OUT_W   = 24;

   // shared multiplier operand and product widths
   localparam int LMA_MUL_W  = 18;
   localparam int LMA_PROD_W = 36;

   // configuration port
   localparam int LMA_CSR_ADDR_W = 2;
   localparam int LMA_CSR_DATA_W = 16;
   localparam logic [LMA_CSR_ADDR_W-1:0] LMA_REG_SELECT_BASE  = 2'd0;
   localparam logic [LMA_CSR_ADDR_W-1:0] LMA_REG_MORPH_ENABLE = 2'd1;
   localparam logic [LMA_CSR_ADDR_W-1:0] LMA_REG_SLEW_ENABLE  = 2'd2;

   // command codes carried in tuser
   localparam logic LMA_CMD_WRITE  = 1'b0;
   localparam logic LMA_CMD_SAMPLE = 1'b1;

endpackage

`default_nettype wire

### rtl/lma_mul.sv
// ----------------------------------------------------------------------------
// lma_mul
// Shared signed multiplier with a registered product, reused by the position, crossfade and gain steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lma_mul (
   input  wire logic                                  clock,
   input  wire logic signed [lma_pkg::LMA_MUL_W-1:0]  op_a,
   input  wire logic signed [lma_pkg::LMA_MUL_W-1:0]  op_b,
   output logic signed      [lma_pkg::LMA_PROD_W-1:0] prod
);

   logic signed [lma_pkg::LMA_PROD_W-1:0] prod_ff;

   // one product per cycle, ready the cycle after the operands
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

### rtl/lma_table.sv
// ----------------------------------------------------------------------------
// lma_table
// Level table memory, one write and one registered read port per cycle.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lma_table #(
   parameter int DEPTH = lma_pkg::LMA_NUM_LAYERS * lma_pkg::LMA_NUM_CHANNELS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   wr_en,
   input  wire logic        [AW-1:0]                   wr_addr,
   input  wire logic signed [lma_pkg::LMA_LEVEL_W-1:0] wr_data,
   input  wire logic        [AW-1:0]                   rd_addr,
   output logic signed      [lma_pkg::LMA_LEVEL_W-1:0] rd_level
);

   logic signed [lma_pkg::LMA_LEVEL_W-1:0] mem_ff [DEPTH];
   logic        [DEPTH-1:0]                vld_ff;
   logic signed [lma_pkg::LMA_LEVEL_W-1:0] rd_data_ff;
   logic                                   rd_vld_ff;

   // storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // valid bits, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // never written entries read as a zero level
   assign rd_level = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

### rtl/layer_morph_attenuator.sv
// ----------------------------------------------------------------------------
// layer_morph_attenuator
// Table driven multi-channel attenuator with layer crossfade and level slew.
// ----------------------------------------------------------------------------
// A write beat (tuser command 0) stores one Q1.15 level for a layer and
// channel; writes to a layer or channel beyond the array are dropped. A sample
// beat (command 1) is worked through a sequencer around one shared 18x18
// multiplier and the single read port of the level table: the block accepts it
// only while idle, then steps through position multiply, clamp, two table
// reads, crossfade multiply, round, slew, gain multiply and output in morph
// mode, or skips the crossfade multiply and round in nearest-layer mode, and
// takes no new beat until it is back in idle. The output register lets the
// next beat in while a result waits; a sample only stalls when the previous
// result is still not taken at its output step. Sample beats on a channel
// beyond the array give no result. Table levels read as zero after reset until
// written; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_morph_attenuator #(
   parameter int NUM_LAYERS   = lma_pkg::LMA_NUM_LAYERS,
   parameter int NUM_CHANNELS = lma_pkg::LMA_NUM_CHANNELS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // tdata: channel, layer_index, level_value, select_offset, sample_in,
   //        input_connected
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [lma_pkg::LMA_IN_W-1:0]         req_tdata,
   // tuser: command
   input  wire logic [0:0]                           req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata: channel_out, sample_out, zero pad
   output logic [lma_pkg::LMA_OUT_W-1:0]             rsp_tdata,
   input  wire logic                                 csr_wr_en,
   input  wire logic [lma_pkg::LMA_CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [lma_pkg::LMA_CSR_DATA_W-1:0]   csr_wdata
);

   localparam int LW    = $clog2(NUM_LAYERS);
   localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DEPTH = NUM_LAYERS * NUM_CHANNELS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(NUM_LAYERS * 65536 + 1);
   localparam int HW    = PW - 16;
   localparam int MW    = lma_pkg::LMA_MUL_W;
   localparam int QW    = lma_pkg::LMA_PROD_W;
   localparam int VW    = lma_pkg::LMA_LEVEL_W;

   localparam logic [PW-1:0]        POS_TOP    = PW'(NUM_LAYERS * 65536);
   localparam logic signed [QW-1:0] POS_TOP_Q  = QW'(NUM_LAYERS * 65536);
   localparam logic [HW-1:0]        LAST_HI    = HW'(NUM_LAYERS - 1);
   localparam logic [HW:0]          LAST_NEAR  = (HW + 1)'(NUM_LAYERS - 1);
   localparam logic [LW-1:0]        LAST_LAYER = LW'(NUM_LAYERS - 1);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_POS   = 4'd1;
   localparam logic [3:0] S_CLAMP = 4'd2;
   localparam logic [3:0] S_RDA   = 4'd3;
   localparam logic [3:0] S_RDB   = 4'd4;
   localparam logic [3:0] S_LERP  = 4'd5;
   localparam logic [3:0] S_MIX   = 4'd6;
   localparam logic [3:0] S_SLEW  = 4'd7;
   localparam logic [3:0] S_MUL   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   // input beat fields
   logic [lma_pkg::LMA_CH_W-1:0]    in_ch;
   logic [lma_pkg::LMA_LAYER_W-1:0] in_layer;
   logic signed [VW-1:0]            in_level;
   logic signed [VW-1:0]            in_offset;
   logic signed [VW-1:0]            in_sample;
   logic                            in_conn;
   logic                            req_beat;

   assign in_ch     = req_tdata[3:0];
   assign in_layer  = req_tdata[6:4];
   assign in_level  = req_tdata[22:7];
   assign in_offset = req_tdata[38:23];
   assign in_sample = req_tdata[54:39];
   assign in_conn   = req_tdata[55];
   assign req_beat  = req_tvalid && req_tready;

   // configuration registers
   logic [15:0] sel_base_ff;
   logic        morph_ff;
   logic        slew_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_base_ff <= '0;
         morph_ff    <= 1'b0;
         slew_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            lma_pkg::LMA_REG_SELECT_BASE:  sel_base_ff <= csr_wdata;
            lma_pkg::LMA_REG_MORPH_ENABLE: morph_ff    <= csr_wdata[0];
            lma_pkg::LMA_REG_SLEW_ENABLE:  slew_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // state and item registers
   logic [3:0]                   state_ff, state_in;
   logic [lma_pkg::LMA_CH_W-1:0] ch_ff;
   logic signed [VW-1:0]         off_ff;
   logic signed [VW-1:0]         smp_ff;
   logic                         conn_ff;
   logic [PW-1:0]                pos_ff, pos_in;
   logic [LW-1:0]                b_ff;
   logic [16:0]                  m_ff;
   logic signed [VW-1:0]         la_ff;
   logic signed [VW-1:0]         target_ff, target_in;
   logic signed [VW-1:0]         level_ff, level_in;
   logic signed [VW-1:0]         last_ff [NUM_CHANNELS];
   logic                         rsp_valid_ff;
   logic [lma_pkg::LMA_CH_W-1:0] rsp_ch_ff;
   logic signed [VW-1:0]         rsp_smp_ff, rsp_smp_in;

   logic [CW-1:0] ch_idx;
   logic          out_free;
   logic          ch_ok;
   logic          wr_ok;

   assign ch_idx   = ch_ff[CW-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ch_ok    = 32'(in_ch) < NUM_CHANNELS;
   assign wr_ok    = ch_ok && (32'(in_layer) < NUM_LAYERS);

   // shared multiplier and level table
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [QW-1:0] mul_p;
   logic                 tbl_wr_en;
   logic [AW-1:0]        tbl_wr_addr;
   logic [AW-1:0]        tbl_rd_addr;
   logic signed [VW-1:0] tbl_level;

   lma_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   assign tbl_wr_en   = (state_ff == S_IDLE) && req_beat &&
                        (req_tuser[0] == lma_pkg::LMA_CMD_WRITE) && wr_ok;
   assign tbl_wr_addr = AW'(32'(in_layer) * NUM_CHANNELS + 32'(in_ch));

   lma_table #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_addr  (tbl_wr_addr),
      .wr_data  (in_level),
      .rd_addr  (tbl_rd_addr),
      .rd_level (tbl_level)
   );

   // select sum and clamp of the scaled position
   logic signed [17:0] sel_sum;
   assign sel_sum = $signed({2'b00, sel_base_ff}) + $signed({off_ff[15], off_ff, 1'b0});

   always_comb begin
      if (mul_p < 0) begin
         pos_in = '0;
      end else if (mul_p > POS_TOP_Q) begin
         pos_in = POS_TOP;
      end else begin
         pos_in = mul_p[PW-1:0];
      end
   end

   // floor layer, next layer and fraction for morph, nearest layer otherwise
   logic [HW-1:0] pos_hi;
   logic [HW-1:0] a_hi;
   logic [PW:0]   pos_rnd;
   logic [HW:0]   near_hi;
   logic [LW-1:0] a_idx;
   logic [LW-1:0] b_idx;
   logic [16:0]   m_val;

   always_comb begin
      pos_hi  = pos_ff[PW-1:16];
      a_hi    = (pos_hi > LAST_HI) ? LAST_HI : pos_hi;
      pos_rnd = {1'b0, pos_ff} + (PW + 1)'(32768);
      near_hi = pos_rnd[PW:16];
      m_val   = {pos_hi != a_hi, pos_ff[15:0]};
      if (morph_ff) begin
         a_idx = a_hi[LW-1:0];
      end else if (near_hi > LAST_NEAR) begin
         a_idx = LAST_LAYER;
      end else begin
         a_idx = near_hi[LW-1:0];
      end
      b_idx = (a_idx == LAST_LAYER) ? a_idx : a_idx + 1'b1;
   end

   // crossfade difference and rounded blend
   logic signed [16:0]   lv_diff;
   logic signed [QW-1:0] mix_rnd;
   logic signed [QW-1:0] mix_sh;

   assign lv_diff   = {tbl_level[15], tbl_level} - {la_ff[15], la_ff};
   assign mix_rnd   = mul_p + QW'(32768);
   assign mix_sh    = mix_rnd >>> 16;
   assign target_in = la_ff + mix_sh[VW-1:0];

   // slew one 128th of the gap, at least one step while a gap remains
   logic signed [VW-1:0] last_cur;
   logic signed [16:0]   sl_d;
   logic signed [16:0]   sl_neg;
   logic signed [16:0]   sl_step;

   always_comb begin
      last_cur = last_ff[ch_idx];
      sl_d     = {target_ff[15], target_ff} - {last_cur[15], last_cur};
      sl_neg   = -sl_d;
      if (sl_d[16]) begin
         sl_step = -(sl_neg >>> 7);
      end else begin
         sl_step = sl_d >>> 7;
      end
      if (sl_step == '0 && sl_d != '0) begin
         sl_step = sl_d[16] ? -17'sd1 : 17'sd1;
      end
      level_in = slew_ff ? last_cur + sl_step[VW-1:0] : target_ff;
   end

   // rounded, saturated gain product, or the level for an open input
   logic signed [QW-1:0] out_rnd;
   logic signed [QW-1:0] out_sh;

   always_comb begin
      out_rnd = mul_p + QW'(16384);
      out_sh  = out_rnd >>> 15;
      if (!conn_ff) begin
         rsp_smp_in = level_ff;
      end else if (out_sh > QW'(32767)) begin
         rsp_smp_in = 16'sh7fff;
      end else if (out_sh < -QW'(32768)) begin
         rsp_smp_in = 16'sh8000;
      end else begin
         rsp_smp_in = out_sh[VW-1:0];
      end
   end

   // multiplier operands and table read address by step
   // gain operands stay on while the output step waits, so the product holds
   always_comb begin
      mul_a       = '0;
      mul_b       = '0;
      tbl_rd_addr = '0;
      unique case (state_ff)
         S_POS: begin
            mul_a = sel_sum;
            mul_b = MW'(NUM_LAYERS);
         end
         S_RDA: begin
            tbl_rd_addr = AW'(32'(a_idx) * NUM_CHANNELS + 32'(ch_idx));
         end
         S_RDB: begin
            tbl_rd_addr = AW'(32'(b_ff) * NUM_CHANNELS + 32'(ch_idx));
         end
         S_LERP: begin
            mul_a = {lv_diff[16], lv_diff};
            mul_b = $signed({1'b0, m_ff});
         end
         S_MUL, S_OUT: begin
            mul_a = {{2{level_ff[15]}}, level_ff};
            mul_b = {{2{smp_ff[15]}}, smp_ff};
         end
         default: ;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat && req_tuser[0] == lma_pkg::LMA_CMD_SAMPLE && ch_ok) begin
               state_in = S_POS;
            end
         end
         S_POS:   state_in = S_CLAMP;
         S_CLAMP: state_in = S_RDA;
         S_RDA:   state_in = S_RDB;
         S_RDB:   state_in = morph_ff ? S_LERP : S_SLEW;
         S_LERP:  state_in = S_MIX;
         S_MIX:   state_in = S_SLEW;
         S_SLEW:  state_in = S_MUL;
         S_MUL:   state_in = S_OUT;
         S_OUT:   state_in = out_free ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // slew memory per channel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_ff[i] <= '0;
         end
      end else if (state_ff == S_SLEW) begin
         last_ff[ch_idx] <= level_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_beat) begin
         ch_ff   <= in_ch;
         off_ff  <= in_offset;
         smp_ff  <= in_sample;
         conn_ff <= in_conn;
      end
      if (state_ff == S_CLAMP) begin
         pos_ff <= pos_in;
      end
      if (state_ff == S_RDA) begin
         b_ff <= b_idx;
         m_ff <= m_val;
      end
      if (state_ff == S_RDB) begin
         la_ff     <= tbl_level;
         target_ff <= tbl_level;
      end
      if (state_ff == S_MIX) begin
         target_ff <= target_in;
      end
      if (state_ff == S_SLEW) begin
         level_ff <= level_in;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_ch_ff  <= ch_ff;
         rsp_smp_ff <= rsp_smp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_smp_ff, rsp_ch_ff};

`ifndef ASSERT_OFF
   // a table write never starts the sample sequence
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_tuser[0] == lma_pkg::LMA_CMD_WRITE) |=> state_ff == S_IDLE)
      else $error("table write left the idle state");

   // an in-range sample beat starts the position step
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_tuser[0] == lma_pkg::LMA_CMD_SAMPLE && ch_ok) |=> state_ff == S_POS)
      else $error("sample beat did not start the sequence");

   // a result appears only out of the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_OUT))
      else $error("result shown outside the output step");

   // the output step waits while an earlier result is stalled
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_tready) |=> state_ff == S_OUT)
      else $error("output step overran a stalled result");
`endif

endmodule

`default_nettype wire
